FILE: hdl/aesctr_pkg.sv
// Package with the payload types, register indexes and AES byte functions.
`default_nettype none
package aesctr_pkg;

    typedef struct packed {
        logic [63:0] data_hi;
        logic [63:0] data_lo;
        logic        hold_counter;
        logic        last_block;
    } t_in_word;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
        logic        last_flag;
    } t_out_word;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_CTR_HI = 3'd4;
    localparam logic [2:0] REG_CTR_LO = 3'd5;

    localparam int STORE_DEPTH = 30;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/aesctr_round.sv
// One AES encryption round on a 128-bit state, combinational.
`default_nettype none
module aesctr_round (
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_round_key,
    input  wire logic         i_final,
    output logic [127:0]      o_state
);
    import aesctr_pkg::*;

    logic [7:0] sb [16];
    logic [7:0] sr [16];
    logic [7:0] mc [16];
    logic [127:0] mix;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[i] = SBOX[i_state[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[4*c+r] = sb[4*((c+r)%4)+r];
            end
        end
        for (int c = 0; c < 4; c++) begin
            mc[4*c]   = xtime(sr[4*c]) ^ xtime(sr[4*c+1]) ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c+1] = sr[4*c] ^ xtime(sr[4*c+1]) ^ xtime(sr[4*c+2]) ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c+2] = sr[4*c] ^ sr[4*c+1] ^ xtime(sr[4*c+2]) ^ xtime(sr[4*c+3]) ^ sr[4*c+3];
            mc[4*c+3] = xtime(sr[4*c]) ^ sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ xtime(sr[4*c+3]);
        end
        for (int i = 0; i < 16; i++) begin
            mix[127-8*i -: 8] = i_final ? sr[i] : mc[i];
        end
        o_state = mix ^ i_round_key;
    end
endmodule
`default_nettype wire

FILE: hdl/aes_counter_mode_crypt.sv
// AES counter mode top level: key schedule memory, iterative round unit, output register.
//
//  channel | valid   | stall   | payload
//  in      | i_valid | o_stall | i_data  (t_in_word)
//  out     | o_valid | i_stall | o_data  (t_out_word)
//  cfg     | i_cfg_we| -       | i_cfg_index, i_cfg_data
//
// Each word takes the first key addition and then Nr rounds (Nr = 10, 12 or 14 for
// 128, 192 or 256 bit keys) in the single round unit, which is reused once per round.
// The last round and the XOR are done in the same cycle, and the block then returns to idle.
// After reset and after every key write, the schedule is expanded into the key memory
// one 32-bit word per cycle (44 to 60 words in all) while no input word is accepted.
// A finished word waits in the output register while the next word is accepted.
`default_nettype none
module aes_counter_mode_crypt #(
    parameter int KEY_BITS = 128
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire aesctr_pkg::t_in_word  i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output aesctr_pkg::t_out_word      o_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [63:0]           i_cfg_data
);
    import aesctr_pkg::*;

    localparam int NK = (KEY_BITS >= 256) ? 8 : ((KEY_BITS >= 192) ? 6 : 4);
    localparam int NR = NK + 6;
    localparam int TOTAL = 4 * (NR + 1);
    localparam logic [5:0] NK_W = 6'(NK);
    localparam logic [2:0] NK_LAST = 3'(NK - 1);
    localparam logic [5:0] LAST_W = 6'(TOTAL - 1);
    localparam logic [3:0] NR_W = 4'(NR);

    localparam logic [1:0] ST_EXPAND = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_ROUND  = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]   r_state;
    logic [63:0]  r_key [4];
    logic [127:0] r_ctr;
    logic [31:0]  r_win [8];
    logic [5:0]   r_widx;
    logic [2:0]   r_pos;
    logic [7:0]   r_rcon;
    logic [127:0] r_ks_mem [15];
    logic [127:0] r_rk;
    logic [3:0]   r_round;
    logic [127:0] r_st;
    t_in_word     r_in;
    logic         r_ovalid;
    t_out_word    r_out;

    logic [31:0]  n_word;
    logic [31:0]  t_prev;
    logic [127:0] rnd_out;
    logic         in_acc;
    logic         out_free;
    logic         key_wr;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign key_wr   = i_cfg_we && (i_cfg_index == REG_KEY0 || i_cfg_index == REG_KEY1 ||
                      i_cfg_index == REG_KEY2 || i_cfg_index == REG_KEY3);
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_ovalid;
    assign o_data   = r_out;

    always_comb begin
        t_prev = r_win[3'(NK - 1)];
        if (r_widx < NK_W) begin
            n_word = (r_widx[0]) ? r_key[r_widx[2:1]][31:0] : r_key[r_widx[2:1]][63:32];
        end else if (r_pos == 3'd0) begin
            n_word = r_win[0] ^ sub_word({t_prev[23:0], t_prev[31:24]}) ^ {r_rcon, 24'd0};
        end else if (NK > 6 && r_pos == 3'd4) begin
            n_word = r_win[0] ^ sub_word(t_prev);
        end else begin
            n_word = r_win[0] ^ t_prev;
        end
    end

    aesctr_round u_round (
        .i_state     (r_st),
        .i_round_key (r_rk),
        .i_final     (r_state == ST_DONE),
        .o_state     (rnd_out)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXPAND && r_widx[1:0] == 2'd3) begin
            r_ks_mem[r_widx[5:2]] <= {r_win[3'(NK - 3)], r_win[3'(NK - 2)],
                                      r_win[3'(NK - 1)], n_word};
        end
        r_rk <= r_ks_mem[(r_state == ST_IDLE) ? 4'd0 : r_round];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_EXPAND;
            r_widx   <= '0;
            r_pos    <= '0;
            r_rcon   <= 8'h01;
            r_ovalid <= 1'b0;
            r_ctr    <= '0;
            r_round  <= '0;
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != ST_DONE || key_wr)) r_ovalid <= 1'b0;
            if (key_wr) begin
                r_state <= ST_EXPAND;
                r_widx  <= '0;
                r_pos   <= '0;
                r_rcon  <= 8'h01;
            end else begin
                unique case (r_state)
                    ST_EXPAND: begin
                        for (int i = 0; i < 7; i++) r_win[i] <= r_win[i+1];
                        r_win[3'(NK - 1)] <= n_word;
                        if (r_widx >= NK_W && r_pos == 3'd0) r_rcon <= xtime(r_rcon);
                        r_pos <= (r_pos == NK_LAST) ? 3'd0 : r_pos + 3'd1;
                        if (r_widx == LAST_W) r_state <= ST_IDLE;
                        r_widx <= r_widx + 6'd1;
                    end
                    ST_IDLE: begin
                        if (in_acc) begin
                            r_in    <= i_data;
                            r_round <= 4'd1;
                            r_state <= ST_ROUND;
                        end
                    end
                    ST_ROUND: begin
                        // r_rk holds key of round r_round-1 here.
                        if (r_round == 4'd1) begin
                            r_st <= r_ctr ^ r_rk;
                        end else begin
                            r_st <= rnd_out;
                        end
                        if (r_round == NR_W) r_state <= ST_DONE;
                        else r_round <= r_round + 4'd1;
                    end
                    ST_DONE: begin
                        if (out_free) begin
                            r_out.result_hi <= r_in.data_hi ^ rnd_out[127:64];
                            r_out.result_lo <= r_in.data_lo ^ rnd_out[63:0];
                            r_out.last_flag <= r_in.last_block;
                            r_ovalid <= 1'b1;
                            if (!r_in.hold_counter) r_ctr <= r_ctr + 128'd1;
                            r_round <= '0;
                            r_state <= ST_IDLE;
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
                        r_key[i_cfg_index[1:0]] <= i_cfg_data;
                    REG_CTR_HI: r_ctr[127:64] <= i_cfg_data;
                    REG_CTR_LO: r_ctr[63:0] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("input accepted while busy");
    a_done_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round <= NR_W + 4'd1)) else $error("round overrun");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_out))) else $error("result lost");
`endif
endmodule
`default_nettype wire
